// ===== hw/rtl/nge_pkg.sv =====
package nge_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEFF_BITS_DEF  = 16;

  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ATTACK    = 2'd0,
    REG_RELEASE   = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_FLOOR     = 2'd3
  } reg_idx_t;

  localparam logic [31:0] ATTACK_RESET    = 32'd64856;
  localparam logic [31:0] RELEASE_RESET   = 32'd65519;
  localparam logic [31:0] THRESHOLD_RESET = 32'd839;
  localparam logic [31:0] FLOOR_RESET     = 32'd7;

endpackage

// ===== hw/rtl/nge_if.sv =====
interface nge_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface nge_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface nge_cfg_if #(
  parameter int IDX_W  = 2,
  parameter int DATA_W = 24
);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/nge_cfg_regs.sv =====
module nge_cfg_regs import nge_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  nge_cfg_if.sink                cfg_chan,
  output logic [COEFF_BITS-1:0]  attack_coeff,
  output logic [COEFF_BITS-1:0]  release_coeff,
  output logic [SAMPLE_BITS-1:0] threshold_level,
  output logic [COEFF_BITS:0]    floor_gain
);

  logic [COEFF_BITS-1:0]  attack_r;
  logic [COEFF_BITS-1:0]  release_r;
  logic [SAMPLE_BITS-1:0] thresh_r;
  logic [COEFF_BITS:0]    floor_r;
  logic                   wr_en;
  reg_idx_t               wr_idx;

  assign cfg_chan.ready = 1'b1;
  assign wr_en  = cfg_chan.valid && cfg_chan.ready;
  assign wr_idx = reg_idx_t'(cfg_chan.reg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= COEFF_BITS'(ATTACK_RESET);
      release_r <= COEFF_BITS'(RELEASE_RESET);
      thresh_r  <= SAMPLE_BITS'(THRESHOLD_RESET);
      floor_r   <= (COEFF_BITS+1)'(FLOOR_RESET);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_ATTACK:    attack_r  <= cfg_chan.wdata[COEFF_BITS-1:0];
        REG_RELEASE:   release_r <= cfg_chan.wdata[COEFF_BITS-1:0];
        REG_THRESHOLD: thresh_r  <= cfg_chan.wdata[SAMPLE_BITS-1:0];
        REG_FLOOR:     floor_r   <= cfg_chan.wdata[COEFF_BITS:0];
        default: ;
      endcase
    end
  end

  assign attack_coeff    = attack_r;
  assign release_coeff   = release_r;
  assign threshold_level = thresh_r;
  assign floor_gain      = floor_r;

endmodule

// ===== hw/rtl/nge_mul.sv =====
module nge_mul #(
  parameter int A_W = 26,
  parameter int B_W = 17,
  parameter int P_W = A_W + B_W + 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [A_W-1:0] a,
  input  logic        [B_W-1:0] b,
  output logic signed [P_W-1:0] p
);

  logic signed [P_W-1:0] a_ext;
  logic signed [P_W-1:0] b_ext;
  logic signed [P_W-1:0] prod_r;

  assign a_ext = P_W'(a);
  assign b_ext = $signed(P_W'(b));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a_ext * b_ext;
    end
  end

  assign p = prod_r;

endmodule

// ===== hw/rtl/noise_gate_envelope.sv =====
// Channel   Dir  Payload                     Transfer when
// in_chan   in   sample_in (S bits, signed)  valid && ready
// out_chan  out  sample_out (S bits, signed) valid && ready
// cfg_chan  in   reg_index, wdata            valid && ready, ready always high
//
// A sample is accepted in the idle state and then passes through six steps that share a
// single multiplier (envelope multiply and update, gain multiply and update, output
// multiply and rounding with saturation).
// The finished result waits in an output register; the last step holds while it is full.
// Reset is synchronous and active low; it restores the register defaults,
// clears the envelope and sets the gate gain to unity.
module noise_gate_envelope import nge_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nge_in_if.sink    in_chan,
  nge_out_if.source out_chan,
  nge_cfg_if.sink   cfg_chan
);

  localparam int A_W = (SAMPLE_BITS + 1 > COEFF_BITS + 2) ? SAMPLE_BITS + 1 : COEFF_BITS + 2;
  localparam int B_W = COEFF_BITS + 1;
  localparam int P_W = A_W + B_W + 1;
  localparam logic [P_W-1:0]         HALF  = P_W'(1) << (COEFF_BITS - 1);
  localparam logic [COEFF_BITS:0]    UNITY = (COEFF_BITS+1)'(1) << COEFF_BITS;
  localparam logic [SAMPLE_BITS-1:0] MAXV  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_GAIN_MUL,
    ST_GAIN_UPD,
    ST_OUT_MUL,
    ST_OUT_SAT
  } state_t;

  logic [COEFF_BITS-1:0]  attack_coeff;
  logic [COEFF_BITS-1:0]  release_coeff;
  logic [SAMPLE_BITS-1:0] threshold_level;
  logic [COEFF_BITS:0]    floor_gain;

  state_t                 state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [SAMPLE_BITS-1:0] env_r, env_nxt;
  logic [COEFF_BITS:0]    gain_r, gain_nxt;
  logic [COEFF_BITS:0]    target_r, target_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic                   in_xfer;
  logic                   out_xfer;
  logic [SAMPLE_BITS-1:0] raw;
  logic [COEFF_BITS:0]    floor_lin;
  logic [COEFF_BITS:0]    target_c;
  logic signed [SAMPLE_BITS:0]  env_diff;
  logic signed [COEFF_BITS+1:0] gain_diff;
  logic [COEFF_BITS-1:0]  env_coeff;
  logic [COEFF_BITS-1:0]  gain_coeff;
  logic                   mul_en;
  logic signed [A_W-1:0]  mul_a;
  logic [B_W-1:0]         mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic signed [P_W-1:0]  rsum;
  logic signed [P_W-1:0]  env_upd;
  logic signed [P_W-1:0]  gain_upd;
  logic [SAMPLE_BITS-1:0] rmag;

  nge_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_cfg_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_chan       (cfg_chan),
    .attack_coeff   (attack_coeff),
    .release_coeff  (release_coeff),
    .threshold_level(threshold_level),
    .floor_gain     (floor_gain)
  );

  nge_mul #(
    .A_W(A_W),
    .B_W(B_W),
    .P_W(P_W)
  ) u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign in_xfer             = in_chan.valid && (state_r == ST_IDLE);
  assign out_xfer            = out_valid_r && out_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;

  assign raw        = in_chan.sample_in;
  assign floor_lin  = (floor_gain > UNITY) ? UNITY : floor_gain;
  assign target_c   = (env_r >= threshold_level) ? UNITY : floor_lin;
  assign env_diff   = $signed({1'b0, env_r}) - $signed({1'b0, mag_r});
  assign gain_diff  = $signed({1'b0, gain_r}) - $signed({1'b0, target_c});
  assign env_coeff  = (mag_r > env_r) ? attack_coeff : release_coeff;
  assign gain_coeff = (target_c > gain_r) ? attack_coeff : release_coeff;

  assign rsum     = (mul_p + $signed(HALF)) >>> COEFF_BITS;
  assign env_upd  = rsum + $signed(P_W'(mag_r));
  assign gain_upd = rsum + $signed(P_W'(target_r));
  assign rmag     = rsum[SAMPLE_BITS-1:0];

  always_comb begin
    mul_en = 1'b0;
    case (state_r)
      ST_ENV_MUL: begin
        mul_en = 1'b1;
        mul_a  = A_W'(env_diff);
        mul_b  = {1'b0, env_coeff};
      end
      ST_GAIN_MUL: begin
        mul_en = 1'b1;
        mul_a  = A_W'(gain_diff);
        mul_b  = {1'b0, gain_coeff};
      end
      ST_OUT_MUL: begin
        mul_en = 1'b1;
        mul_a  = A_W'($signed({1'b0, mag_r}));
        mul_b  = gain_r;
      end
      default: begin
        mul_a = A_W'($signed({1'b0, mag_r}));
        mul_b = gain_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    env_nxt       = env_r;
    gain_nxt      = gain_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt   = raw[SAMPLE_BITS-1];
          mag_nxt   = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(-raw) : raw;
          state_nxt = ST_ENV_MUL;
        end
      end
      ST_ENV_MUL: state_nxt = ST_ENV_UPD;
      ST_ENV_UPD: begin
        env_nxt   = env_upd[SAMPLE_BITS-1:0];
        state_nxt = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        target_nxt = target_c;
        state_nxt  = ST_GAIN_UPD;
      end
      ST_GAIN_UPD: begin
        gain_nxt  = gain_upd[COEFF_BITS:0];
        state_nxt = ST_OUT_MUL;
      end
      ST_OUT_MUL: state_nxt = ST_OUT_SAT;
      ST_OUT_SAT: begin
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_data_nxt = SAMPLE_BITS'(-rmag);
          end else if (rmag[SAMPLE_BITS-1]) begin
            out_data_nxt = MAXV;
          end else begin
            out_data_nxt = rmag;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_r       <= '0;
      gain_r      <= UNITY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    target_r   <= target_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/nge_checker.sv =====
module nge_checker import nge_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample_out,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // The block works on one sample at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  // No result can come out of the multiplier sequence in the cycle after a transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early after an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("stalled result changed or dropped");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write not taken");

endmodule

bind noise_gate_envelope nge_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_nge_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .sample_out(out_chan.sample_out),
  .cfg_valid (cfg_chan.valid),
  .cfg_ready (cfg_chan.ready)
);
